@@ rtl/core/ndsq_pkg.sv @@
// Shared types and constants for the nutrient and pH dosing sequencer.
package ndsq_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned PhW    = 11;
	localparam int unsigned TdsW   = 16;
	localparam int unsigned DurW   = 20;
	localparam int unsigned MaskW  = 4;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 20;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_WATER   = 3'd1,
		MODE_NUT_INJ = 3'd2,
		MODE_NUT_MIX = 3'd3,
		MODE_PH_INJ  = 3'd4,
		MODE_PH_MIX  = 3'd5,
		MODE_FORCED  = 3'd6
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PH_MIN      = 3'd0,
		REG_PH_MAX      = 3'd1,
		REG_TDS_MIN     = 3'd2,
		REG_TDS_MAX     = 3'd3,
		REG_NUT_INJ_MS  = 3'd4,
		REG_PH_INJ_MS   = 3'd5,
		REG_MIX_LOCK_MS = 3'd6
	} cfg_reg_t;

	// pump drive bit positions
	localparam int unsigned P_WATER = 0;
	localparam int unsigned P_NUT   = 1;
	localparam int unsigned P_PH    = 2;
	localparam int unsigned P_MIX   = 3;

	localparam logic [DurW-1:0] NUT_INJ_MS_RST  = 20'd3000;
	localparam logic [DurW-1:0] PH_INJ_MS_RST   = 20'd3000;
	localparam logic [DurW-1:0] MIX_LOCK_MS_RST = 20'd15000;

endpackage

@@ rtl/core/nutrient_ph_dosing_sequencer.sv @@
// Nutrient and pH dosing sequencer: mode FSM, dosing timers and pump drive.
// A result beat is valid in the cycle after its input beat is taken.
// Throughput: one evaluation per cycle; the state registers double as the result
// register, so input is stalled only while a result beat is held by out_stall.
// Reset: mode idle, all pumps off, timer starts zero, thresholds zero,
// inject times 3000 ms, mix lock 15000 ms; no result pending.
module nutrient_ph_dosing_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ndsq_pkg::TimeW-1:0]      now_ms,
	input  logic [ndsq_pkg::PhW-1:0]        ph_reading,
	input  logic [ndsq_pkg::TdsW-1:0]       tds_reading,
	input  logic                            water_request,
	input  logic [ndsq_pkg::MaskW-1:0]      force_enable_mask,
	input  logic [ndsq_pkg::MaskW-1:0]      force_value_mask,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      mode,
	output logic                            water_on,
	output logic                            nutrient_pump_on,
	output logic                            phdown_pump_on,
	output logic                            mixer_pump_on,
	input  logic                            cfg_we,
	input  logic [ndsq_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [ndsq_pkg::CfgDataW-1:0]   cfg_data
);

	// configuration
	logic [ndsq_pkg::PhW-1:0]  ph_min_q, ph_max_q;
	logic [ndsq_pkg::TdsW-1:0] tds_min_q, tds_max_q;
	logic [ndsq_pkg::DurW-1:0] nut_inj_ms_q, ph_inj_ms_q, mix_lock_ms_q;

	// sequencer state
	ndsq_pkg::mode_t            mode_q, mode_d;
	logic [ndsq_pkg::MaskW-1:0] pump_q, pump_d;
	logic [ndsq_pkg::TimeW-1:0] nut_start_q, ph_start_q, mix_start_q;
	logic                       out_valid_q;

	logic accept;
	logic force_on, tds_ok, ph_ok;
	logic idle_tds_hit, idle_ph_hit;
	logic nut_exp, ph_exp, mix_exp;
	logic tds_done, ph_done;
	logic set_nut_start, set_ph_start;
	logic [ndsq_pkg::TimeW-1:0] nut_elapsed, ph_elapsed, mix_elapsed;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_min_q      <= '0;
			ph_max_q      <= '0;
			tds_min_q     <= '0;
			tds_max_q     <= '0;
			nut_inj_ms_q  <= ndsq_pkg::NUT_INJ_MS_RST;
			ph_inj_ms_q   <= ndsq_pkg::PH_INJ_MS_RST;
			mix_lock_ms_q <= ndsq_pkg::MIX_LOCK_MS_RST;
		end else if (cfg_we) begin
			case (ndsq_pkg::cfg_reg_t'(cfg_index))
				ndsq_pkg::REG_PH_MIN:      ph_min_q      <= cfg_data[ndsq_pkg::PhW-1:0];
				ndsq_pkg::REG_PH_MAX:      ph_max_q      <= cfg_data[ndsq_pkg::PhW-1:0];
				ndsq_pkg::REG_TDS_MIN:     tds_min_q     <= cfg_data[ndsq_pkg::TdsW-1:0];
				ndsq_pkg::REG_TDS_MAX:     tds_max_q     <= cfg_data[ndsq_pkg::TdsW-1:0];
				ndsq_pkg::REG_NUT_INJ_MS:  nut_inj_ms_q  <= cfg_data;
				ndsq_pkg::REG_PH_INJ_MS:   ph_inj_ms_q   <= cfg_data;
				ndsq_pkg::REG_MIX_LOCK_MS: mix_lock_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign force_on = |force_enable_mask;
	assign tds_ok   = (tds_min_q != '0) && (tds_max_q != '0) && (tds_reading != '0);
	assign ph_ok    = (ph_min_q != '0) && (ph_max_q != '0) && (ph_reading != '0);

	assign idle_tds_hit = tds_ok && (tds_reading <= tds_min_q);
	assign idle_ph_hit  = ph_ok && (ph_reading >= ph_max_q);
	// mix-phase exits skip the availability check
	assign tds_done = (tds_reading >= tds_max_q) || force_on;
	assign ph_done  = (ph_reading <= ph_min_q) || force_on;

	// wrapping elapsed time, expired when strictly above the duration
	assign nut_elapsed = now_ms - nut_start_q;
	assign ph_elapsed  = now_ms - ph_start_q;
	assign mix_elapsed = now_ms - mix_start_q;
	assign nut_exp = nut_elapsed > {{(ndsq_pkg::TimeW-ndsq_pkg::DurW){1'b0}}, nut_inj_ms_q};
	assign ph_exp  = ph_elapsed  > {{(ndsq_pkg::TimeW-ndsq_pkg::DurW){1'b0}}, ph_inj_ms_q};
	assign mix_exp = mix_elapsed > {{(ndsq_pkg::TimeW-ndsq_pkg::DurW){1'b0}}, mix_lock_ms_q};

	assign set_nut_start = ((mode_q == ndsq_pkg::MODE_IDLE) && idle_tds_hit) ||
		((mode_q == ndsq_pkg::MODE_NUT_MIX) && mix_exp);
	assign set_ph_start  = ((mode_q == ndsq_pkg::MODE_IDLE) && idle_ph_hit) ||
		((mode_q == ndsq_pkg::MODE_PH_MIX) && mix_exp);

	// next mode: later tests override earlier ones
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			ndsq_pkg::MODE_IDLE: begin
				if (idle_tds_hit) mode_d = ndsq_pkg::MODE_NUT_INJ;
				if (idle_ph_hit) mode_d = ndsq_pkg::MODE_PH_INJ;
				if (water_request) mode_d = ndsq_pkg::MODE_WATER;
				if (force_on) mode_d = ndsq_pkg::MODE_FORCED;
			end
			ndsq_pkg::MODE_WATER: begin
				if (!water_request) mode_d = ndsq_pkg::MODE_IDLE;
			end
			ndsq_pkg::MODE_NUT_INJ: begin
				if (force_on) mode_d = ndsq_pkg::MODE_IDLE;
				if (nut_exp) mode_d = ndsq_pkg::MODE_NUT_MIX;
			end
			ndsq_pkg::MODE_NUT_MIX: begin
				if (mix_exp) mode_d = ndsq_pkg::MODE_NUT_INJ;
				if (tds_done) mode_d = ndsq_pkg::MODE_IDLE;
			end
			ndsq_pkg::MODE_PH_INJ: begin
				if (force_on) mode_d = ndsq_pkg::MODE_IDLE;
				if (ph_exp) mode_d = ndsq_pkg::MODE_PH_MIX;
			end
			ndsq_pkg::MODE_PH_MIX: begin
				if (mix_exp) mode_d = ndsq_pkg::MODE_PH_INJ;
				if (ph_done) mode_d = ndsq_pkg::MODE_IDLE;
			end
			ndsq_pkg::MODE_FORCED: begin
				if (!force_on) mode_d = ndsq_pkg::MODE_IDLE;
			end
			default: mode_d = mode_q;
		endcase
	end

	// pump drive: actions accumulate in test order
	always_comb begin
		pump_d = pump_q;
		case (mode_q)
			ndsq_pkg::MODE_IDLE: begin
				if (idle_tds_hit) begin
					pump_d[ndsq_pkg::P_NUT] = 1'b1;
					pump_d[ndsq_pkg::P_MIX] = 1'b1;
				end
				if (idle_ph_hit) begin
					pump_d[ndsq_pkg::P_PH]  = 1'b1;
					pump_d[ndsq_pkg::P_MIX] = 1'b1;
				end
				if (water_request) pump_d[ndsq_pkg::P_WATER] = 1'b1;
			end
			ndsq_pkg::MODE_WATER: begin
				if (!water_request) pump_d[ndsq_pkg::P_WATER] = 1'b0;
			end
			ndsq_pkg::MODE_NUT_INJ: begin
				if (force_on) begin
					pump_d[ndsq_pkg::P_NUT] = 1'b0;
					pump_d[ndsq_pkg::P_MIX] = 1'b0;
				end
				if (nut_exp) pump_d[ndsq_pkg::P_NUT] = 1'b0;
			end
			ndsq_pkg::MODE_NUT_MIX: begin
				if (mix_exp) pump_d[ndsq_pkg::P_NUT] = 1'b1;
				if (tds_done) begin
					pump_d[ndsq_pkg::P_NUT] = 1'b0;
					pump_d[ndsq_pkg::P_MIX] = 1'b0;
				end
			end
			ndsq_pkg::MODE_PH_INJ: begin
				if (force_on) begin
					pump_d[ndsq_pkg::P_PH]  = 1'b0;
					pump_d[ndsq_pkg::P_MIX] = 1'b0;
				end
				if (ph_exp) pump_d[ndsq_pkg::P_PH] = 1'b0;
			end
			ndsq_pkg::MODE_PH_MIX: begin
				if (mix_exp) pump_d[ndsq_pkg::P_PH] = 1'b1;
				if (ph_done) begin
					pump_d[ndsq_pkg::P_PH]  = 1'b0;
					pump_d[ndsq_pkg::P_MIX] = 1'b0;
				end
			end
			ndsq_pkg::MODE_FORCED: begin
				if (!force_on) pump_d = '0;
				pump_d = (pump_d & ~force_enable_mask) | (force_value_mask & force_enable_mask);
			end
			default: pump_d = pump_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= ndsq_pkg::MODE_IDLE;
			pump_q      <= '0;
			nut_start_q <= '0;
			ph_start_q  <= '0;
			mix_start_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				pump_q <= pump_d;
				if (set_nut_start) nut_start_q <= now_ms;
				if (set_ph_start) ph_start_q <= now_ms;
				if (set_nut_start || set_ph_start) mix_start_q <= now_ms;
			end
			// hold the result beat until taken
			if (accept) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign mode             = mode_q;
	assign water_on         = pump_q[ndsq_pkg::P_WATER];
	assign nutrient_pump_on = pump_q[ndsq_pkg::P_NUT];
	assign phdown_pump_on   = pump_q[ndsq_pkg::P_PH];
	assign mixer_pump_on    = pump_q[ndsq_pkg::P_MIX];

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q) else $error("accepted beat produced no result");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(mode_q) && $stable(pump_q) && $stable(mix_start_q)))
		else $error("sequencer state moved without an input beat");

	a_water_pump: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ndsq_pkg::MODE_WATER) |-> pump_q[ndsq_pkg::P_WATER])
		else $error("water mode with water pump off");

	a_nut_mix_pump: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ndsq_pkg::MODE_NUT_MIX) |-> !pump_q[ndsq_pkg::P_NUT])
		else $error("nutrient pump on while mixing");

	a_ph_mix_pump: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ndsq_pkg::MODE_PH_MIX) |-> !pump_q[ndsq_pkg::P_PH])
		else $error("pH-downer pump on while mixing");

endmodule
